/* sv/mmcp_pkg.sv */
// Shared constants for the motor command packer: register map and datapath widths.
// Used by mmcp_lane.sv and mit_motor_command_packer.sv; depends on nothing.
package mmcp_pkg;

  localparam int unsigned VAL_W    = 33;  // signed command value after offset and inversion
  localparam int unsigned SPAN_W   = 32;  // hi - lo of a nonempty range
  localparam int unsigned DIV_STEPS = 16; // quotient bits produced, one per stage
  localparam int unsigned NUM_W    = 50;  // width of off * 2N + span
  localparam int unsigned REM_W    = 33;  // remainder below 2 * span
  localparam int unsigned LANE_LAT = DIV_STEPS + 2;

  localparam int unsigned CFG_AW = 5;

  localparam logic [2:0] REG_POS_MIN     = 3'd0;
  localparam logic [2:0] REG_POS_MAX     = 3'd1;
  localparam logic [2:0] REG_VEL_MIN     = 3'd2;
  localparam logic [2:0] REG_VEL_MAX     = 3'd3;
  localparam logic [2:0] REG_TOR_MIN     = 3'd4;
  localparam logic [2:0] REG_TOR_MAX     = 3'd5;
  localparam logic [2:0] REG_ZERO_OFFSET = 3'd6;
  localparam logic [2:0] REG_SIGN_FLAGS  = 3'd7;

  localparam logic [1:0] OP_RUN  = 2'd1;
  localparam logic [1:0] OP_DAMP = 2'd2;

endpackage

/* sv/mmcp_lane.sv */
// One field of the packer: clamp, build the rounding numerator, and a pipelined
// restoring divider with one quotient bit per stage. Depends on mmcp_pkg.
module mmcp_lane #(
  parameter int unsigned NB = 16
) (
  input  logic                                    clk,
  input  logic                                    en,
  input  logic signed [mmcp_pkg::VAL_W-1:0]       val_i,
  input  logic signed [mmcp_pkg::VAL_W-1:0]       lo_i,
  input  logic signed [mmcp_pkg::VAL_W-1:0]       hi_i,
  input  logic                                    kill_i,
  output logic [NB-1:0]                           code_o
);

  localparam int unsigned ST = mmcp_pkg::DIV_STEPS;

  logic signed [mmcp_pkg::VAL_W-1:0] clamp_c;
  logic [mmcp_pkg::VAL_W-1:0]        off_full_c;
  logic [mmcp_pkg::VAL_W-1:0]        span_full_c;

  logic [mmcp_pkg::SPAN_W-1:0] off_r;
  logic [mmcp_pkg::SPAN_W-1:0] span_r;
  logic                        zero_r;

  logic [mmcp_pkg::NUM_W-1:0]  num_c;

  logic [mmcp_pkg::REM_W-1:0]  rem_r  [0:ST];
  logic [ST-1:0]               low_r  [0:ST];
  logic [ST-1:0]               quo_r  [0:ST];
  logic [mmcp_pkg::REM_W-1:0]  div_r  [0:ST];
  logic                        z_r    [0:ST];

  always_comb begin
    if (val_i < lo_i) begin
      clamp_c = lo_i;
    end else if (val_i > hi_i) begin
      clamp_c = hi_i;
    end else begin
      clamp_c = val_i;
    end
    off_full_c  = clamp_c - lo_i;
    span_full_c = hi_i - lo_i;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      off_r  <= off_full_c[mmcp_pkg::SPAN_W-1:0];
      span_r <= span_full_c[mmcp_pkg::SPAN_W-1:0];
      zero_r <= kill_i | (lo_i >= hi_i);
    end
  end

  // off * 2N with N = 2^NB - 1, plus span for round half up.
  assign num_c = ({{(mmcp_pkg::NUM_W-mmcp_pkg::SPAN_W){1'b0}}, off_r} << (NB + 1))
               - ({{(mmcp_pkg::NUM_W-mmcp_pkg::SPAN_W){1'b0}}, off_r} << 1)
               + {{(mmcp_pkg::NUM_W-mmcp_pkg::SPAN_W){1'b0}}, span_r};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num_c[mmcp_pkg::NUM_W-2:ST];
      low_r[0] <= num_c[ST-1:0];
      quo_r[0] <= '0;
      div_r[0] <= {span_r, 1'b0};
      z_r[0]   <= zero_r;
    end
  end

  for (genvar k = 0; k < ST; k++) begin : g_step
    logic [mmcp_pkg::REM_W:0] trial_c;
    logic [mmcp_pkg::REM_W:0] diff_c;
    logic                     ge_c;
    assign trial_c = {rem_r[k], low_r[k][ST-1]};
    assign diff_c  = trial_c - {1'b0, div_r[k]};
    assign ge_c    = trial_c >= {1'b0, div_r[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge_c ? diff_c[mmcp_pkg::REM_W-1:0] : trial_c[mmcp_pkg::REM_W-1:0];
        low_r[k+1] <= {low_r[k][ST-2:0], 1'b0};
        quo_r[k+1] <= {quo_r[k][ST-2:0], ge_c};
        div_r[k+1] <= div_r[k];
        z_r[k+1]   <= z_r[k];
      end
    end
  end

  assign code_o = z_r[ST] ? '0 : quo_r[ST][NB-1:0];

endmodule

/* sv/mit_motor_command_packer.sv */
// Top level of the MIT-mode motor command packer: APB registers, value stages, five lanes.
// Depends on mmcp_pkg and mmcp_lane.
//
// Each beat on the input stream is one motor command; each output beat is the eight-byte
// CAN payload for it, byte zero in tdata[63:56]. A command may enter every cycle unless
// the output stalls. Its payload passes the input register, the value stage, the clamp
// register, the rounding-numerator register, the sixteen-stage divider in each lane,
// which yields one quotient bit per stage, and the output register. Back pressure on the
// output halts the whole pipeline. Registers should be written only while no command is
// in flight.
module mit_motor_command_packer #(
  parameter logic [31:0] KP_MAX = 32'd32768000,
  parameter logic [31:0] KD_MAX = 32'd327680
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [159:0]                     in_tdata,  // target_position, target_velocity,
                                                      // stiffness_gain, damping_gain,
                                                      // feedforward_torque
  input  logic [1:0]                       in_tuser,  // operation
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [63:0]                      out_tdata, // payload
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [mmcp_pkg::CFG_AW-1:0]      cfg_paddr,
  input  logic [31:0]                      cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready
);

  localparam int unsigned VW  = mmcp_pkg::VAL_W;
  localparam int unsigned LAT = mmcp_pkg::LANE_LAT + 2;

  logic [31:0] pos_min_r, pos_max_r, vel_min_r, vel_max_r, tor_min_r, tor_max_r;
  logic [31:0] zero_offset_r;
  logic [2:0]  sign_flags_r;
  logic [2:0]  reg_idx;
  logic        cfg_wr;

  logic        adv;
  logic [LAT-1:0] vld_r;

  logic [1:0]  op_r;
  logic [31:0] tp_r, tv_r, kp_r, kd_r, tt_r;

  logic signed [VW-1:0] pos_nxt, vel_nxt, kpv_nxt, kdv_nxt, tor_nxt;
  logic signed [VW-1:0] pos_r, vel_r, kpv_r, kdv_r, tor_r;
  logic                 kill_r;
  logic signed [VW-1:0] diff_c;

  logic [15:0] pos_code;
  logic [11:0] vel_code, kp_code, kd_code, tor_code;

  logic        out_valid_r;
  logic [63:0] out_data_r;

  assign reg_idx    = cfg_paddr[4:2];
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_min_r     <= -32'sd819200;
      pos_max_r     <= 32'sd819200;
      vel_min_r     <= -32'sd1966080;
      vel_max_r     <= 32'sd1966080;
      tor_min_r     <= -32'sd655360;
      tor_max_r     <= 32'sd655360;
      zero_offset_r <= '0;
      sign_flags_r  <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        mmcp_pkg::REG_POS_MIN:     pos_min_r     <= cfg_pwdata;
        mmcp_pkg::REG_POS_MAX:     pos_max_r     <= cfg_pwdata;
        mmcp_pkg::REG_VEL_MIN:     vel_min_r     <= cfg_pwdata;
        mmcp_pkg::REG_VEL_MAX:     vel_max_r     <= cfg_pwdata;
        mmcp_pkg::REG_TOR_MIN:     tor_min_r     <= cfg_pwdata;
        mmcp_pkg::REG_TOR_MAX:     tor_max_r     <= cfg_pwdata;
        mmcp_pkg::REG_ZERO_OFFSET: zero_offset_r <= cfg_pwdata;
        mmcp_pkg::REG_SIGN_FLAGS:  sign_flags_r  <= cfg_pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mmcp_pkg::REG_POS_MIN:     cfg_prdata = pos_min_r;
      mmcp_pkg::REG_POS_MAX:     cfg_prdata = pos_max_r;
      mmcp_pkg::REG_VEL_MIN:     cfg_prdata = vel_min_r;
      mmcp_pkg::REG_VEL_MAX:     cfg_prdata = vel_max_r;
      mmcp_pkg::REG_TOR_MIN:     cfg_prdata = tor_min_r;
      mmcp_pkg::REG_TOR_MAX:     cfg_prdata = tor_max_r;
      mmcp_pkg::REG_ZERO_OFFSET: cfg_prdata = zero_offset_r;
      mmcp_pkg::REG_SIGN_FLAGS:  cfg_prdata = {29'd0, sign_flags_r};
      default:                   cfg_prdata = '0;
    endcase
  end

  assign adv       = ~out_valid_r | out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[LAT-2:0], in_tvalid};
      out_valid_r <= vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op_r <= in_tuser;
      tp_r <= in_tdata[31:0];
      tv_r <= in_tdata[63:32];
      kp_r <= in_tdata[95:64];
      kd_r <= in_tdata[127:96];
      tt_r <= in_tdata[159:128];
    end
  end

  // Run mode applies the zero offset and the per-axis inversions; damp keeps only kd.
  assign diff_c = VW'($signed(tp_r)) - VW'($signed(zero_offset_r));

  always_comb begin
    pos_nxt = '0;
    vel_nxt = '0;
    kpv_nxt = '0;
    tor_nxt = '0;
    kdv_nxt = VW'($signed(kd_r));
    if (op_r == mmcp_pkg::OP_RUN) begin
      pos_nxt = sign_flags_r[0] ? -diff_c : diff_c;
      vel_nxt = sign_flags_r[1] ? -VW'($signed(tv_r)) : VW'($signed(tv_r));
      tor_nxt = sign_flags_r[2] ? -VW'($signed(tt_r)) : VW'($signed(tt_r));
      kpv_nxt = VW'($signed(kp_r));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pos_r  <= pos_nxt;
      vel_r  <= vel_nxt;
      kpv_r  <= kpv_nxt;
      kdv_r  <= kdv_nxt;
      tor_r  <= tor_nxt;
      kill_r <= (op_r != mmcp_pkg::OP_RUN) && (op_r != mmcp_pkg::OP_DAMP);
    end
  end

  mmcp_lane #(.NB(16)) u_pos (
    .clk(clk), .en(adv), .val_i(pos_r),
    .lo_i(VW'($signed(pos_min_r))), .hi_i(VW'($signed(pos_max_r))),
    .kill_i(kill_r), .code_o(pos_code)
  );

  mmcp_lane #(.NB(12)) u_vel (
    .clk(clk), .en(adv), .val_i(vel_r),
    .lo_i(VW'($signed(vel_min_r))), .hi_i(VW'($signed(vel_max_r))),
    .kill_i(kill_r), .code_o(vel_code)
  );

  mmcp_lane #(.NB(12)) u_kp (
    .clk(clk), .en(adv), .val_i(kpv_r),
    .lo_i('0), .hi_i(VW'(KP_MAX)),
    .kill_i(kill_r), .code_o(kp_code)
  );

  mmcp_lane #(.NB(12)) u_kd (
    .clk(clk), .en(adv), .val_i(kdv_r),
    .lo_i('0), .hi_i(VW'(KD_MAX)),
    .kill_i(kill_r), .code_o(kd_code)
  );

  mmcp_lane #(.NB(12)) u_tor (
    .clk(clk), .en(adv), .val_i(tor_r),
    .lo_i(VW'($signed(tor_min_r))), .hi_i(VW'($signed(tor_max_r))),
    .kill_i(kill_r), .code_o(tor_code)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= {pos_code, vel_code, kp_code, kd_code, tor_code};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
